### hdl/c3mf_pkg.sv
// Package for the 3x3 multi-filter convolution block.
// Shared types, field widths, command codes and the pixel centering function.
// No dependencies.
package c3mf_pkg;

  localparam int KERNEL_SIZE = 3;
  localparam int TAPS        = KERNEL_SIZE * KERNEL_SIZE;
  localparam int MAX_WIDTH   = 64;
  localparam int MAX_ROWS    = 64;
  localparam int MAX_FILTERS = 8;

  localparam int COL_W     = 6;
  localparam int ROW_W     = 6;
  localparam int FILT_W    = 3;
  localparam int TAP_W     = 4;
  localparam int PIX_W     = 8;
  localparam int WEIGHT_W  = 16;
  localparam int CENTER_W  = PIX_W + 1;
  localparam int PROD_W    = WEIGHT_W + CENTER_W;
  localparam int GROUP_W   = 27;
  localparam int SUM_W     = 28;
  localparam int CFG_W     = 7;
  localparam int NF_W      = 4;
  localparam int REG_IDX_W = 2;

  localparam logic [REG_IDX_W-1:0] REG_IMAGE_COLS     = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_IMAGE_ROWS     = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_FILTERS_IN_USE = 2'd2;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_PIXEL = 1'b1;

  typedef enum logic {
    JOB_LOAD  = 1'b0,
    JOB_PIXEL = 1'b1
  } job_kind_t;

  typedef struct packed {
    logic                       cmd;
    logic [FILT_W-1:0]          load_filter;
    logic [TAP_W-1:0]           load_tap;
    logic signed [WEIGHT_W-1:0] weight_value;
    logic [PIX_W-1:0]           pixel;
  } conv_in_t;

  typedef struct packed {
    logic [FILT_W-1:0]       filter_id;
    logic [ROW_W-1:0]        out_row;
    logic [COL_W-1:0]        out_col;
    logic signed [SUM_W-1:0] conv_sum;
    logic                    last;
  } conv_out_t;

  typedef struct packed {
    logic [CFG_W-1:0] cols;
    logic [CFG_W-1:0] rows;
    logic [NF_W-1:0]  nf;
  } cfg_t;

  typedef struct packed {
    logic one;
    logic two;
  } q_room_t;

  typedef struct packed {
    job_kind_t                    kind;
    logic [FILT_W-1:0]            filt;
    logic [TAP_W-1:0]             tap;
    logic [WEIGHT_W-1:0]          weight;
    logic [TAPS-1:0][PIX_W-1:0]   win;
    logic [ROW_W-1:0]             orow;
    logic [COL_W-1:0]             ocol;
  } job_t;

  // 2p - 255 in nine bits
  function automatic logic signed [CENTER_W-1:0] center(input logic [PIX_W-1:0] p);
    return {~p[PIX_W-1], p[PIX_W-2:0], 1'b1};
  endfunction

endpackage

### hdl/conv3x3_multi_filter_top.sv
// Top level of the streaming 3x3 convolution bank for up to eight filters.
// Holds the configuration registers; joins front end, job queue and back end.
// Depends on c3mf_pkg, c3mf_front, c3mf_queue, c3mf_back.
//
//   channel  handshake            payload           direction
//   in       in_valid/in_ready    in_data (items)   into block
//   out      out_valid/out_ready  out_data (sums)   out of block
//   cfg      cfg_we               cfg_index/data    into block, no wait
//
// Front end takes one item per cycle while the job queue has room.
// Back end writes each weight load on its own and runs each window position once per
// active filter, one filter per cycle from the per-tap weight banks unless frozen.
// A pixel passes the input register, the job queue and the s1, product, group and output registers.
// Reset clears the line buffer valid bits; the RAMs need no clearing pass.
// out_ready low with out_valid set freezes the back end; in_ready drops as the queue fills.
module conv3x3_multi_filter_top #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  c3mf_pkg::conv_in_t                    in_data,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output c3mf_pkg::conv_out_t                   out_data,
  input  logic                                  cfg_we,
  input  logic [c3mf_pkg::REG_IDX_W-1:0]        cfg_index,
  input  logic [c3mf_pkg::CFG_W-1:0]            cfg_data
);
  import c3mf_pkg::*;

  logic [CFG_W-1:0] image_cols;
  logic [CFG_W-1:0] image_rows;
  logic [NF_W-1:0]  filters_in_use;
  cfg_t             cfg;
  logic             push;
  job_t             job;
  job_t             head;
  logic             empty;
  logic             pop;
  q_room_t          room;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_cols     <= CFG_W'(28);
      image_rows     <= CFG_W'(28);
      filters_in_use <= NF_W'(8);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_IMAGE_COLS:     image_cols     <= cfg_data;
        REG_IMAGE_ROWS:     image_rows     <= cfg_data;
        REG_FILTERS_IN_USE: filters_in_use <= cfg_data[NF_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (image_cols < CFG_W'(KERNEL_SIZE)) begin
      cfg.cols = CFG_W'(KERNEL_SIZE);
    end else if (image_cols > CFG_W'(MAX_WIDTH)) begin
      cfg.cols = CFG_W'(MAX_WIDTH);
    end else begin
      cfg.cols = image_cols;
    end
    if (image_rows < CFG_W'(KERNEL_SIZE)) begin
      cfg.rows = CFG_W'(KERNEL_SIZE);
    end else if (image_rows > CFG_W'(MAX_ROWS)) begin
      cfg.rows = CFG_W'(MAX_ROWS);
    end else begin
      cfg.rows = image_rows;
    end
    if (filters_in_use == '0) begin
      cfg.nf = NF_W'(1);
    end else if (filters_in_use > NF_W'(MAX_FILTERS)) begin
      cfg.nf = NF_W'(MAX_FILTERS);
    end else begin
      cfg.nf = filters_in_use;
    end
  end

  c3mf_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .room     (room),
    .push     (push),
    .job      (job)
  );

  c3mf_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (job),
    .pop   (pop),
    .head  (head),
    .empty (empty),
    .room  (room)
  );

  c3mf_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .head      (head),
    .empty     (empty),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

### hdl/c3mf_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module c3mf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hdl/c3mf_front.sv
// Front end: accepts items, tracks raster position, keeps line buffers and window.
// Classifies items into weight loads and window jobs for the queue.
// Depends on c3mf_pkg and c3mf_ram.
module c3mf_front (
  input  logic               clk,
  input  logic               rst,
  input  c3mf_pkg::cfg_t     cfg,
  input  logic               in_valid,
  output logic               in_ready,
  input  c3mf_pkg::conv_in_t in_data,
  input  c3mf_pkg::q_room_t  room,
  output logic               push,
  output c3mf_pkg::job_t     job
);
  import c3mf_pkg::*;

  logic                         accept;
  logic                         a_valid;
  conv_in_t                     a_item;
  logic [COL_W-1:0]             a_col;
  logic [ROW_W-1:0]             a_row;
  logic [COL_W-1:0]             col_count;
  logic [ROW_W-1:0]             row_count;
  logic [TAPS-1:0][PIX_W-1:0]   win;
  logic [TAPS-1:0][PIX_W-1:0]   win_next;
  logic [MAX_WIDTH-1:0]         lb_vld;
  logic [PIX_W-1:0]             lb_a_rd;
  logic [PIX_W-1:0]             lb_b_rd;
  logic [PIX_W-1:0]             lb_a_val;
  logic [PIX_W-1:0]             lb_b_val;
  logic                         a_pix;
  logic                         at_out;
  logic                         col_wrap;
  logic                         row_wrap;

  assign in_ready = a_valid ? room.two : room.one;
  assign accept   = in_valid && in_ready;

  assign col_wrap = (CFG_W'(col_count) + CFG_W'(1)) >= cfg.cols;
  assign row_wrap = (CFG_W'(row_count) + CFG_W'(1)) >= cfg.rows;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      col_count <= '0;
      row_count <= '0;
    end else begin
      a_valid <= accept &&
                 (in_data.cmd == CMD_PIXEL || in_data.load_tap < TAP_W'(TAPS));
      if (accept && in_data.cmd == CMD_PIXEL) begin
        if (col_wrap) begin
          col_count <= '0;
          row_count <= row_wrap ? '0 : row_count + ROW_W'(1);
        end else begin
          col_count <= col_count + COL_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_item <= in_data;
      a_col  <= col_count;
      a_row  <= row_count;
    end
  end

  c3mf_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_lb_a (
    .clk   (clk),
    .we    (a_pix),
    .waddr (a_col),
    .wdata (a_item.pixel),
    .re    (1'b1),
    .raddr (col_count),
    .rdata (lb_a_rd)
  );

  c3mf_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_lb_b (
    .clk   (clk),
    .we    (a_pix),
    .waddr (a_col),
    .wdata (lb_a_val),
    .re    (1'b1),
    .raddr (col_count),
    .rdata (lb_b_rd)
  );

  assign a_pix    = a_valid && a_item.cmd == CMD_PIXEL;
  assign lb_a_val = lb_vld[a_col] ? lb_a_rd : '0;
  assign lb_b_val = lb_vld[a_col] ? lb_b_rd : '0;

  always_comb begin
    win_next = win;
    for (int r = 0; r < KERNEL_SIZE; r++) begin
      for (int c = 0; c < KERNEL_SIZE - 1; c++) begin
        win_next[r*KERNEL_SIZE + c] = win[r*KERNEL_SIZE + c + 1];
      end
    end
    win_next[KERNEL_SIZE - 1]     = lb_b_val;
    win_next[2*KERNEL_SIZE - 1]   = lb_a_val;
    win_next[TAPS - 1]            = a_item.pixel;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win    <= '0;
      lb_vld <= '0;
    end else if (a_pix) begin
      win           <= win_next;
      lb_vld[a_col] <= 1'b1;
    end
  end

  assign at_out = a_row >= ROW_W'(KERNEL_SIZE - 1) && a_col >= COL_W'(KERNEL_SIZE - 1);
  assign push   = a_valid && (a_item.cmd == CMD_LOAD || at_out);

  always_comb begin
    job.kind   = (a_item.cmd == CMD_LOAD) ? JOB_LOAD : JOB_PIXEL;
    job.filt   = a_item.load_filter;
    job.tap    = a_item.load_tap;
    job.weight = a_item.weight_value;
    job.win    = win_next;
    job.orow   = a_row - ROW_W'(KERNEL_SIZE - 1);
    job.ocol   = a_col - COL_W'(KERNEL_SIZE - 1);
  end

endmodule

### hdl/c3mf_queue.sv
// Short job queue between front end and back end, built from flip-flops.
// Reports free room for one and for two more jobs.
// Depends on c3mf_pkg.
module c3mf_queue #(
  parameter int DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  c3mf_pkg::job_t    wdata,
  input  logic              pop,
  output c3mf_pkg::job_t    head,
  output logic              empty,
  output c3mf_pkg::q_room_t room
);
  import c3mf_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  job_t          mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign head      = mem[rd_ptr];
  assign empty     = count == '0;
  assign room.one  = count < CW'(DEPTH);
  assign room.two  = count < CW'(DEPTH - 1);

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

### hdl/c3mf_back.sv
// Back end: writes weights and runs each window job through all active filters.
// Weight banks per tap, product stage, partial sum stage, output register.
// Depends on c3mf_pkg and c3mf_ram.
module c3mf_back (
  input  logic                clk,
  input  logic                rst,
  input  c3mf_pkg::cfg_t      cfg,
  input  c3mf_pkg::job_t      head,
  input  logic                empty,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_ready,
  output c3mf_pkg::conv_out_t out_data
);
  import c3mf_pkg::*;

  typedef struct packed {
    logic [FILT_W-1:0] filter_id;
    logic [ROW_W-1:0]  out_row;
    logic [COL_W-1:0]  out_col;
    logic              last;
  } meta_t;

  logic                       en;
  logic                       issue;
  logic                       wload;
  logic                       last_f;
  logic [FILT_W-1:0]          f_cnt;
  logic                       s1_valid;
  meta_t                      s1_meta;
  logic [TAPS-1:0][PIX_W-1:0] s1_win;
  logic [WEIGHT_W-1:0]        w_rd [TAPS];
  logic                       p_valid;
  meta_t                      p_meta;
  logic signed [PROD_W-1:0]   p_prod [TAPS];
  logic                       g_valid;
  meta_t                      g_meta;
  logic signed [GROUP_W-1:0]  g_sum [KERNEL_SIZE];
  logic signed [SUM_W-1:0]    sum_all;

  assign en     = !out_valid || out_ready;
  assign issue  = en && !empty && head.kind == JOB_PIXEL;
  assign wload  = en && !empty && head.kind == JOB_LOAD;
  assign last_f = (NF_W'(f_cnt) + NF_W'(1)) == cfg.nf;
  assign pop    = wload || (issue && last_f);

  always_ff @(posedge clk) begin
    if (rst) begin
      f_cnt <= '0;
    end else if (issue) begin
      f_cnt <= last_f ? '0 : f_cnt + FILT_W'(1);
    end
  end

  for (genvar t = 0; t < TAPS; t++) begin : g_bank
    c3mf_ram #(.WIDTH(WEIGHT_W), .DEPTH(MAX_FILTERS)) u_wbank (
      .clk   (clk),
      .we    (wload && head.tap == TAP_W'(t)),
      .waddr (head.filt),
      .wdata (head.weight),
      .re    (en),
      .raddr (f_cnt),
      .rdata (w_rd[t])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      p_valid   <= 1'b0;
      g_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      s1_valid  <= issue;
      p_valid   <= s1_valid;
      g_valid   <= p_valid;
      out_valid <= g_valid;
    end
  end

  always_comb begin
    sum_all = '0;
    for (int k = 0; k < KERNEL_SIZE; k++) begin
      sum_all = sum_all + SUM_W'(g_sum[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_meta.filter_id <= f_cnt;
      s1_meta.out_row   <= head.orow;
      s1_meta.out_col   <= head.ocol;
      s1_meta.last      <= last_f;
      s1_win            <= head.win;

      p_meta <= s1_meta;
      for (int t = 0; t < TAPS; t++) begin
        p_prod[t] <= PROD_W'($signed(w_rd[t])) * PROD_W'(center(s1_win[t]));
      end

      g_meta <= p_meta;
      for (int k = 0; k < KERNEL_SIZE; k++) begin
        g_sum[k] <= GROUP_W'(p_prod[k*KERNEL_SIZE])
                  + GROUP_W'(p_prod[k*KERNEL_SIZE + 1])
                  + GROUP_W'(p_prod[k*KERNEL_SIZE + 2]);
      end

      out_data.filter_id <= g_meta.filter_id;
      out_data.out_row   <= g_meta.out_row;
      out_data.out_col   <= g_meta.out_col;
      out_data.conv_sum  <= sum_all;
      out_data.last      <= g_meta.last;
    end
  end

endmodule

### verif/conv3x3_multi_filter_top_tb.sv
`timescale 1ns / 1ps
// Testbench for conv3x3_multi_filter_top: weight loads and pixel streams with random
// idling on both channels, checked against a behavioral model of the filter bank.
// Depends on c3mf_pkg and the RTL of the block.
module conv3x3_multi_filter_top_tb;
  import c3mf_pkg::*;

  class conv_scoreboard;
    logic signed [WEIGHT_W-1:0] weights [MAX_FILTERS*TAPS];
    logic [PIX_W-1:0] line_a [MAX_WIDTH];
    logic [PIX_W-1:0] line_b [MAX_WIDTH];
    logic [PIX_W-1:0] win [KERNEL_SIZE][KERNEL_SIZE];
    int col_pos;
    int row_pos;
    logic [CFG_W-1:0] cols_reg;
    logic [CFG_W-1:0] rows_reg;
    logic [NF_W-1:0] nf_reg;
    conv_out_t sums_due [$];
    int errors;

    function new();
      for (int i = 0; i < MAX_FILTERS*TAPS; i++) weights[i] = '0;
      for (int i = 0; i < MAX_WIDTH; i++) begin
        line_a[i] = '0;
        line_b[i] = '0;
      end
      for (int r = 0; r < KERNEL_SIZE; r++)
        for (int c = 0; c < KERNEL_SIZE; c++) win[r][c] = '0;
      col_pos = 0;
      row_pos = 0;
      cols_reg = CFG_W'(28);
      rows_reg = CFG_W'(28);
      nf_reg = NF_W'(8);
      errors = 0;
    endfunction

    function int clamp(int v, int lo, int hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
    endfunction

    function int pending();
      return sums_due.size();
    endfunction

    function void set_reg(logic [REG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      case (idx)
        REG_IMAGE_COLS: cols_reg = data;
        REG_IMAGE_ROWS: rows_reg = data;
        REG_FILTERS_IN_USE: nf_reg = data[NF_W-1:0];
        default: ;
      endcase
    endfunction

    function void note_item(conv_in_t it);
      int cols;
      int rows;
      int nf;
      int col;
      int acc;
      conv_out_t sum;
      if (it.cmd == CMD_LOAD) begin
        if (it.load_tap < TAPS) weights[it.load_filter*TAPS + it.load_tap] = it.weight_value;
        return;
      end
      cols = clamp(int'(cols_reg), KERNEL_SIZE, MAX_WIDTH);
      rows = clamp(int'(rows_reg), KERNEL_SIZE, MAX_ROWS);
      nf = clamp(int'(nf_reg), 1, MAX_FILTERS);
      col = col_pos % MAX_WIDTH;
      for (int r = 0; r < KERNEL_SIZE; r++)
        for (int c = 0; c + 1 < KERNEL_SIZE; c++) win[r][c] = win[r][c+1];
      win[0][KERNEL_SIZE-1] = line_b[col];
      win[1][KERNEL_SIZE-1] = line_a[col];
      win[2][KERNEL_SIZE-1] = it.pixel;
      line_b[col] = line_a[col];
      line_a[col] = it.pixel;
      if (row_pos >= KERNEL_SIZE - 1 && col >= KERNEL_SIZE - 1) begin
        for (int f = 0; f < nf; f++) begin
          acc = 0;
          for (int r = 0; r < KERNEL_SIZE; r++)
            for (int c = 0; c < KERNEL_SIZE; c++)
              acc += weights[f*TAPS + r*KERNEL_SIZE + c] * (2 * int'(win[r][c]) - 255);
          sum.filter_id = FILT_W'(f);
          sum.out_row = ROW_W'(row_pos - (KERNEL_SIZE - 1));
          sum.out_col = COL_W'(col - (KERNEL_SIZE - 1));
          sum.conv_sum = SUM_W'(acc);
          sum.last = (f == nf - 1);
          sums_due.push_back(sum);
        end
      end
      if (col_pos + 1 >= cols) begin
        col_pos = 0;
        row_pos = (row_pos + 1 >= rows) ? 0 : row_pos + 1;
      end else begin
        col_pos++;
      end
    endfunction

    function void compare_field(string name, logic signed [63:0] want, logic signed [63:0] got);
      if (got !== want) begin
        errors++;
        if (errors <= 100)
          $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      end
    endfunction

    function void check_sum(conv_out_t got);
      conv_out_t want;
      if (sums_due.size() == 0) begin
        errors++;
        if (errors <= 100)
          $display("%0t: unexpected sum, expected none, got %h", $time, got);
        return;
      end
      want = sums_due.pop_front();
      compare_field("filter_id", 64'(want.filter_id), 64'(got.filter_id));
      compare_field("out_row", 64'(want.out_row), 64'(got.out_row));
      compare_field("out_col", 64'(want.out_col), 64'(got.out_col));
      compare_field("conv_sum", 64'(want.conv_sum), 64'(got.conv_sum));
      compare_field("last", 64'(want.last), 64'(got.last));
    endfunction
  endclass

  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_CYCLES = 20;
  localparam int HOLD_CYCLES = 400;
  localparam int RANDOM_ITEMS = 410;
  localparam logic [REG_IDX_W-1:0] REG_UNUSED = 2'd3;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_ready;
  conv_in_t in_data;
  logic out_valid;
  logic out_ready;
  conv_out_t out_data;
  logic cfg_we;
  logic [REG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;

  conv_scoreboard sums;
  int hold_count;
  int cycles;
  bit gap_free;

  conv3x3_multi_filter_top i_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (gap_free || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [WEIGHT_W-1:0] pick_weight();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return 16'h8000;
    if (r < 20) return 16'h7FFF;
    if (r < 25) return 16'h0000;
    if (r < 30) return 16'hFFFF;
    return WEIGHT_W'($urandom_range(0, 65535));
  endfunction

  function automatic logic [PIX_W-1:0] pick_pixel();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return 8'd0;
    if (r < 16) return 8'd255;
    return PIX_W'($urandom_range(0, 255));
  endfunction

  function automatic logic [CFG_W-1:0] pick_size();
    int r;
    r = $urandom_range(0, 99);
    if (r < 85) return CFG_W'($urandom_range(3, 12));
    if (r < 95) return CFG_W'($urandom_range(13, 64));
    return CFG_W'($urandom_range(0, 127));
  endfunction

  function automatic conv_in_t load_item(int f, int t, logic [WEIGHT_W-1:0] w);
    conv_in_t it;
    it = conv_in_t'($urandom);
    it.cmd = CMD_LOAD;
    it.load_filter = FILT_W'(f);
    it.load_tap = TAP_W'(t);
    it.weight_value = w;
    return it;
  endfunction

  function automatic conv_in_t pixel_item(logic [PIX_W-1:0] p);
    conv_in_t it;
    it = conv_in_t'($urandom);
    it.cmd = CMD_PIXEL;
    it.pixel = p;
    return it;
  endfunction

  task automatic offer(input conv_in_t it);
    int gap;
    in_data <= it;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sums.note_item(it);
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    sums.set_reg(idx, data);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (sums.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // sink side: random stalls, plus long hold-offs on request
  initial begin
    int stall_left;
    int run_left;
    int holds_seen;
    stall_left = 0;
    run_left = 0;
    holds_seen = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst === 1'b0 && out_valid && out_ready) sums.check_sum(out_data);
      if (hold_count != holds_seen) begin
        holds_seen = hold_count;
        stall_left = HOLD_CYCLES;
        run_left = 0;
      end
      if (stall_left == 0 && run_left == 0) begin
        run_left = ($urandom_range(0, 99) < 8) ? $urandom_range(60, 160) : $urandom_range(1, 24);
        case ($urandom_range(0, 19)) inside
          0: stall_left = $urandom_range(20, 60);
          [1:5]: stall_left = $urandom_range(4, 12);
          default: stall_left = $urandom_range(1, 3);
        endcase
      end
      if (run_left > 0) begin
        run_left--;
        out_ready <= 1'b1;
      end else begin
        stall_left--;
        out_ready <= 1'b0;
      end
    end
  end

  initial begin
    int sent;
    int phase;
    int len;
    int r;
    logic [CFG_W-1:0] cols_set;
    logic [CFG_W-1:0] rows_set;
    logic [CFG_W-1:0] nf_set;
    conv_in_t it;
    sums = new();
    rst <= 1'b1;
    in_valid <= 1'b0;
    in_data <= '0;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    hold_count <= 0;
    gap_free = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // smallest image, one filter, full-scale sums of both signs
    write_reg(REG_IMAGE_COLS, 7'd3);
    write_reg(REG_IMAGE_ROWS, 7'd3);
    write_reg(REG_FILTERS_IN_USE, 7'd1);
    write_reg(REG_UNUSED, 7'h55);
    for (int t = 0; t < TAPS; t++) offer(load_item(0, t, 16'h8000));
    offer(load_item(7, 15, 16'h7FFF));
    for (int i = 0; i < TAPS; i++) offer(pixel_item(8'd0));
    for (int i = 0; i < TAPS; i++) offer(pixel_item(8'd255));
    settle();

    // fill the whole weight bank before any wider filter set reads it
    sent = 0;
    for (int f = 0; f < MAX_FILTERS; f++)
      for (int t = 0; t < TAPS; t++) begin
        offer(load_item(f, t, pick_weight()));
        sent++;
      end

    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      case (phase)
        0: begin
          cols_set = 7'd3;
          rows_set = 7'd64;
          nf_set = 7'd8;
          len = 200;
        end
        1: begin
          cols_set = 7'd64;
          rows_set = 7'd127;
          nf_set = 7'd1;
          len = 40;
        end
        2: begin
          cols_set = 7'd0;
          rows_set = 7'd2;
          nf_set = 7'd0;
          len = 30;
        end
        3: begin
          cols_set = 7'd127;
          rows_set = 7'd0;
          nf_set = 7'h7F;
          len = 30;
        end
        default: begin
          cols_set = pick_size();
          rows_set = pick_size();
          nf_set = ($urandom_range(0, 99) < 80) ? CFG_W'($urandom_range(1, 8))
                                                : CFG_W'($urandom_range(0, 15));
          len = $urandom_range(20, 50);
        end
      endcase
      settle();
      write_reg(REG_IMAGE_COLS, cols_set);
      write_reg(REG_IMAGE_ROWS, rows_set);
      write_reg(REG_FILTERS_IN_USE, nf_set);
      gap_free = ($urandom_range(0, 3) == 0);
      if (phase == 0) hold_count <= hold_count + 1;
      for (int i = 0; i < len; i++) begin
        r = $urandom_range(0, 99);
        if (r < 90) it = pixel_item(pick_pixel());
        else if (r < 97) it = load_item($urandom_range(0, 7), $urandom_range(0, 8), pick_weight());
        else it = load_item($urandom_range(0, 7), $urandom_range(9, 15), pick_weight());
        offer(it);
        sent++;
      end
      phase++;
    end
    settle();

    if (sums.errors == 0 && sums.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule

### conv3x3_multi_filter_top.f
hdl/c3mf_pkg.sv
hdl/c3mf_ram.sv
hdl/c3mf_front.sv
hdl/c3mf_queue.sv
hdl/c3mf_back.sv
hdl/conv3x3_multi_filter_top.sv
verif/conv3x3_multi_filter_top_tb.sv
